### hw/rtl/mae_pkg.sv
// Package for the matrix arithmetic engine: widths, mode codes, queue entry type.
// No dependencies.
package mae_pkg;
    localparam int MAX_DIM = 8;
    localparam int FRAC_BITS = 16;
    localparam int IDX_W = 3;
    localparam int ADDR_W = 6;
    localparam int DIM_W = 4;
    localparam int ACC_W = 70;
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] MODE_MUL = 2'd0;
    localparam logic [1:0] MODE_ADD = 2'd1;
    localparam logic [1:0] MODE_SCALE = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_OP_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_ROWS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_A_COLS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE = 3'd4;

    typedef struct packed {
        logic              sel_b;
        logic [ADDR_W-1:0] addr;
        logic [31:0]       value;
        logic              go;
    } load_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        r = d;
        if (d == '0)
            r = DIM_W'(1);
        else if (d > DIM_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        return r;
    endfunction
endpackage

### hw/rtl/mae_front.sv
// Front end: accepts load items and pushes them into a two-entry queue.
// Depends on mae_pkg.
module mae_front import mae_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        req_type,
    input  logic [2:0]  elem_row,
    input  logic [2:0]  elem_col,
    input  logic [31:0] elem_value,
    input  logic        load_last,
    output logic        busy,
    input  logic        pop,
    output logic        q_valid,
    output load_t       q_head
);
    load_t       q_reg [2];
    logic [1:0]  cnt_reg, cnt_next;
    logic        push;
    load_t       item;

    assign busy = (cnt_reg == 2'd2);
    assign push = start && !busy;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_head = q_reg[0];

    always_comb
    begin
        item.sel_b = req_type;
        item.addr = {elem_row, elem_col};
        item.value = elem_value;
        item.go = load_last;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (push && cnt_reg == 2'd1)
                q_reg[0] <= item;
            else
                q_reg[0] <= q_reg[1];
        end
        else if (push)
        begin
            if (cnt_reg == 2'd0)
                q_reg[0] <= item;
            else
                q_reg[1] <= item;
        end
    end
endmodule

### hw/rtl/mae_back.sv
// Back end: element stores and the sequencer that computes result elements.
// Depends on mae_pkg.
module mae_back import mae_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  load_t       q_head,
    output logic        pop,
    input  logic [1:0]  op_mode,
    input  logic [DIM_W-1:0] a_rows,
    input  logic [DIM_W-1:0] a_cols,
    input  logic [DIM_W-1:0] b_cols,
    input  logic [31:0] scale_factor,
    output logic        valid,
    output logic [2:0]  out_row,
    output logic [2:0]  out_col,
    output logic [31:0] out_value,
    output logic        saturated,
    output logic        last_result
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD = 3'd1;
    localparam logic [2:0] ST_MUL = 3'd2;
    localparam logic [2:0] ST_ACC = 3'd3;
    localparam logic [2:0] ST_FIN = 3'd4;

    logic [31:0] mem_a [MAX_DIM*MAX_DIM];
    logic [31:0] mem_b [MAX_DIM*MAX_DIM];

    logic [2:0] st_reg, st_next;
    logic [IDX_W-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [DIM_W-1:0] rows, cols, inner;
    logic [1:0] mode_reg, mode_next;
    logic [31:0] ra_reg, rb_reg;
    logic signed [63:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [ADDR_W-1:0] addr_a, addr_b;
    logic kl_reg, kl_next;
    logic signed [ACC_W-1:0] shifted;
    logic go;
    logic last_elem;
    logic [2:0] o_row_reg, o_col_reg;
    logic [31:0] o_val_reg;
    logic o_sat_reg, o_last_reg, o_vld_reg;

    assign rows = clamp_dim(a_rows);
    assign inner = clamp_dim(a_cols);
    assign cols = (mode_reg == MODE_MUL) ? clamp_dim(b_cols) : inner;
    assign pop = q_valid && (st_reg == ST_IDLE);
    assign go = pop && q_head.go && (op_mode != MODE_NONE);
    assign last_elem = ({1'b0, i_reg} == rows - 1'b1) && ({1'b0, j_reg} == cols - 1'b1);

    always_comb
    begin
        addr_a = (mode_reg == MODE_MUL) ? {i_reg, k_reg} : {i_reg, j_reg};
        addr_b = (mode_reg == MODE_MUL) ? {k_reg, j_reg} : {i_reg, j_reg};
        shifted = (mode_reg == MODE_ADD) ? acc_reg : (acc_reg >>> FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (pop && !q_head.sel_b)
            mem_a[q_head.addr] <= q_head.value;
        if (pop && q_head.sel_b)
            mem_b[q_head.addr] <= q_head.value;
        ra_reg <= mem_a[addr_a];
        rb_reg <= mem_b[addr_b];
        case (mode_reg)
            MODE_MUL: prod_reg <= $signed(ra_reg) * $signed(rb_reg);
            MODE_ADD: prod_reg <= 64'($signed(ra_reg)) + 64'($signed(rb_reg));
            default:  prod_reg <= $signed(ra_reg) * $signed(scale_factor);
        endcase
        acc_reg <= acc_next;
    end

    // store reads are registered: every inner step passes through ST_RD so the
    // operands in ST_MUL belong to the current k
    always_comb
    begin
        st_next = st_reg;
        i_next = i_reg;
        j_next = j_reg;
        k_next = k_reg;
        mode_next = mode_reg;
        kl_next = kl_reg;
        acc_next = acc_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (go)
                begin
                    st_next = ST_RD;
                    mode_next = op_mode;
                    i_next = '0;
                    j_next = '0;
                    k_next = '0;
                end
            end
            ST_RD:
            begin
                if (k_reg == '0)
                    acc_next = '0;
                st_next = ST_MUL;
                kl_next = (mode_reg != MODE_MUL) || ({1'b0, k_reg} == inner - 1'b1);
            end
            ST_MUL:
                st_next = ST_ACC;
            ST_ACC:
            begin
                acc_next = acc_reg + ACC_W'(prod_reg);
                if (kl_reg)
                    st_next = ST_FIN;
                else
                begin
                    k_next = k_reg + 1'b1;
                    st_next = ST_RD;
                end
            end
            ST_FIN:
            begin
                k_next = '0;
                if (last_elem)
                    st_next = ST_IDLE;
                else
                begin
                    st_next = ST_RD;
                    if ({1'b0, j_reg} == cols - 1'b1)
                    begin
                        j_next = '0;
                        i_next = i_reg + 1'b1;
                    end
                    else
                        j_next = j_reg + 1'b1;
                end
            end
            default:
                st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            o_vld_reg <= 1'b0;
            i_reg <= '0;
            j_reg <= '0;
            k_reg <= '0;
            mode_reg <= MODE_MUL;
            kl_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            i_reg <= i_next;
            j_reg <= j_next;
            k_reg <= k_next;
            mode_reg <= mode_next;
            kl_reg <= kl_next;
            o_vld_reg <= (st_reg == ST_FIN);
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_FIN)
        begin
            o_row_reg <= i_reg;
            o_col_reg <= j_reg;
            o_last_reg <= last_elem;
            if (shifted > ACC_W'(64'sh7FFFFFFF))
            begin
                o_val_reg <= 32'h7FFFFFFF;
                o_sat_reg <= 1'b1;
            end
            else if (shifted < -ACC_W'(64'sh80000000))
            begin
                o_val_reg <= 32'h80000000;
                o_sat_reg <= 1'b1;
            end
            else
            begin
                o_val_reg <= shifted[31:0];
                o_sat_reg <= 1'b0;
            end
        end
    end

    assign valid = o_vld_reg;
    assign out_row = o_row_reg;
    assign out_col = o_col_reg;
    assign out_value = o_val_reg;
    assign saturated = o_sat_reg;
    assign last_result = o_last_reg;
endmodule

### hw/rtl/matrix_arithmetic_engine.sv
// Top level of the matrix arithmetic engine: config registers, front end, back end.
// Depends on mae_pkg, mae_front, mae_back.
// Loads are taken one per cycle while busy is low into a two-entry queue; busy
// rises only while the queue is full, which happens while a computation runs.
// Each result element takes a read, multiply and accumulate step per inner term in
// product mode and one such step otherwise, then a finish step, as the single shared
// multiplier-accumulator reads one element of each store per step. Results appear
// on valid for one cycle each and cannot be held off.
module matrix_arithmetic_engine import mae_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        req_type,
    input  logic [2:0]  elem_row,
    input  logic [2:0]  elem_col,
    input  logic [31:0] elem_value,
    input  logic        load_last,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        valid,
    output logic [2:0]  out_row,
    output logic [2:0]  out_col,
    output logic [31:0] out_value,
    output logic        saturated,
    output logic        last_result
);
    logic [1:0]  op_mode_reg;
    logic [DIM_W-1:0] a_rows_reg, a_cols_reg, b_cols_reg;
    logic [31:0] scale_reg;
    logic        pop, q_valid;
    load_t       q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_mode_reg <= MODE_MUL;
            a_rows_reg <= DIM_W'(MAX_DIM);
            a_cols_reg <= DIM_W'(MAX_DIM);
            b_cols_reg <= DIM_W'(MAX_DIM);
            scale_reg <= 32'h0001_0000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_OP_MODE: op_mode_reg <= cfg_data[1:0];
                REG_A_ROWS:  a_rows_reg <= cfg_data[DIM_W-1:0];
                REG_A_COLS:  a_cols_reg <= cfg_data[DIM_W-1:0];
                REG_B_COLS:  b_cols_reg <= cfg_data[DIM_W-1:0];
                REG_SCALE:   scale_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    mae_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .req_type(req_type),
        .elem_row(elem_row), .elem_col(elem_col), .elem_value(elem_value),
        .load_last(load_last), .busy(busy), .pop(pop), .q_valid(q_valid),
        .q_head(q_head)
    );

    mae_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_head(q_head), .pop(pop),
        .op_mode(op_mode_reg), .a_rows(a_rows_reg), .a_cols(a_cols_reg),
        .b_cols(b_cols_reg), .scale_factor(scale_reg), .valid(valid),
        .out_row(out_row), .out_col(out_col), .out_value(out_value),
        .saturated(saturated), .last_result(last_result)
    );
endmodule

### hw/rtl/mae_checker.sv
// Port-level checks for the matrix arithmetic engine, bound to the top level.
// Depends on matrix_arithmetic_engine ports only.
module mae_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       valid,
    input logic       last_result,
    input logic       saturated,
    input logic [31:0] out_value,
    input logic [2:0] out_col
);
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        valid && saturated |-> out_value == 32'h7FFFFFFF || out_value == 32'h80000000)
        else $error("saturated value not at a limit");
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        valid |=> !valid)
        else $error("results back to back");
    a_first_col: assert property (@(posedge clk) disable iff (!rst_n)
        valid && last_result |=> ##4 (!valid || out_col == 3'd0))
        else $error("new matrix does not start at column zero");
endmodule

bind matrix_arithmetic_engine mae_checker u_mae_checker (
    .clk(clk), .rst_n(rst_n), .valid(valid), .last_result(last_result),
    .saturated(saturated), .out_value(out_value), .out_col(out_col)
);

### bench/testbench.sv
// Testbench for matrix_arithmetic_engine: directed table, then random load and compute jobs.
// Results are compared against an in-bench Q16.16 matrix predictor. Depends on mae_pkg.
module testbench import mae_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 60;
    localparam int ITEM_TARGET = 430;

    typedef struct {
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] value;
        logic        sat;
        logic        last;
    } elem_t;

    typedef struct {
        bit          is_cfg;
        logic [2:0]  idx;
        logic [31:0] data;
        bit          sel_b;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] value;
        bit          last;
        bit          typed;
        logic [31:0] exp_value;
        bit          exp_sat;
    } step_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        req_type;
    logic [2:0]  elem_row;
    logic [2:0]  elem_col;
    logic [31:0] elem_value;
    logic        load_last;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        valid;
    logic [2:0]  out_row;
    logic [2:0]  out_col;
    logic [31:0] out_value;
    logic        saturated;
    logic        last_result;

    matrix_arithmetic_engine uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .elem_row(elem_row), .elem_col(elem_col),
        .elem_value(elem_value), .load_last(load_last),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .valid(valid), .out_row(out_row), .out_col(out_col),
        .out_value(out_value), .saturated(saturated), .last_result(last_result)
    );

    // predictor state
    logic [31:0] mat_a [64];
    logic [31:0] mat_b [64];
    bit          wr_a [64];
    bit          wr_b [64];
    logic [1:0]  mode_reg;
    logic [3:0]  rows_reg;
    logic [3:0]  cols_reg;
    logic [3:0]  bcols_reg;
    logic [31:0] scale_reg;

    elem_t       elem_expect_q [$];
    int          errors = 0;
    int          items_sent = 0;
    int          stall_cnt = 0;
    bit          no_idle = 0;

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    function automatic void queue_expect(elem_t e);
        elem_expect_q.insert(elem_expect_q.size(), e);
    endfunction

    function automatic int dim_of(logic [3:0] d);
        return (d == 0) ? 1 : ((d > MAX_DIM) ? MAX_DIM : int'(d));
    endfunction

    function automatic void finish_elem(logic signed [71:0] acc, int shift, int i, int j,
                                        bit is_last);
        logic signed [71:0] sh;
        elem_t e;
        sh = acc >>> shift;
        e.row = i[2:0];
        e.col = j[2:0];
        e.last = is_last;
        e.sat = 1'b1;
        if (sh > 72'sd2147483647)
            e.value = 32'h7FFF_FFFF;
        else if (sh < -72'sd2147483648)
            e.value = 32'h8000_0000;
        else
        begin
            e.value = sh[31:0];
            e.sat = 1'b0;
        end
        queue_expect(e);
    endfunction

    function automatic void compute_matrix();
        int nr, ni, nc;
        logic signed [71:0] acc;
        longint pa, pb;
        nr = dim_of(rows_reg);
        ni = dim_of(cols_reg);
        nc = (mode_reg == MODE_MUL) ? dim_of(bcols_reg) : ni;
        for (int i = 0; i < nr; i++)
            for (int j = 0; j < nc; j++)
            begin
                acc = 0;
                if (mode_reg == MODE_MUL)
                begin
                    for (int k = 0; k < ni; k++)
                    begin
                        pa = $signed(mat_a[i*8+k]);
                        pb = $signed(mat_b[k*8+j]);
                        acc += pa * pb;
                    end
                    finish_elem(acc, FRAC_BITS, i, j, i == nr-1 && j == nc-1);
                end
                else if (mode_reg == MODE_ADD)
                begin
                    pa = $signed(mat_a[i*8+j]);
                    pb = $signed(mat_b[i*8+j]);
                    acc = pa + pb;
                    finish_elem(acc, 0, i, j, i == nr-1 && j == nc-1);
                end
                else
                begin
                    pa = $signed(mat_a[i*8+j]);
                    pb = $signed(scale_reg);
                    acc = pa * pb;
                    finish_elem(acc, FRAC_BITS, i, j, i == nr-1 && j == nc-1);
                end
            end
    endfunction

    // results cannot be held off: check on every strobe
    always @(posedge clk)
    begin
        elem_t e;
        if (rst_n && valid)
        begin
            if (elem_expect_q.size() == 0)
            begin
                $display("%0t: unexpected result row %0d col %0d value %h", $time,
                         out_row, out_col, out_value);
                errors++;
            end
            else
            begin
                e = elem_expect_q.pop_front();
                if (out_row !== e.row || out_col !== e.col || out_value !== e.value ||
                    saturated !== e.sat || last_result !== e.last)
                begin
                    $display("%0t: mismatch expected r%0d c%0d %h sat%0b last%0b", $time,
                             e.row, e.col, e.value, e.sat, e.last);
                    $display("%0t:          actual   r%0d c%0d %h sat%0b last%0b", $time,
                             out_row, out_col, out_value, saturated, last_result);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || valid)
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (elem_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_OP_MODE: mode_reg = data[1:0];
            REG_A_ROWS:  rows_reg = data[3:0];
            REG_A_COLS:  cols_reg = data[3:0];
            REG_B_COLS:  bcols_reg = data[3:0];
            REG_SCALE:   scale_reg = data;
            default: ;
        endcase
    endtask

    // returns once the item is accepted; start stays high
    task automatic send_load(bit sel_b, logic [2:0] r, logic [2:0] c, logic [31:0] v,
                             bit lst, output int n_new);
        int before_n;
        while (!no_idle && $urandom_range(99) < 31)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req_type <= sel_b;
        elem_row <= r;
        elem_col <= c;
        elem_value <= v;
        load_last <= lst;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
        if (sel_b)
        begin
            mat_b[{r, c}] = v;
            wr_b[{r, c}] = 1;
        end
        else
        begin
            mat_a[{r, c}] = v;
            wr_a[{r, c}] = 1;
        end
        before_n = elem_expect_q.size();
        if (lst && mode_reg != MODE_NONE)
            compute_matrix();
        n_new = elem_expect_q.size() - before_n;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(32'h0004_0000);
            3: return -$urandom_range(32'h0004_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [3:0] rand_dim();
        case ($urandom_range(19))
            0: return 4'd0;
            1: return 4'd15;
            2, 3: return 4'd8;
            default: return 4'($urandom_range(1, 3));
        endcase
    endfunction

    // fill every unwritten entry the next computation reads; rewrite reloads others at random
    task automatic cover_operands(bit rewrite);
        int nr, ni, nc, n;
        nr = dim_of(rows_reg);
        ni = dim_of(cols_reg);
        nc = dim_of(bcols_reg);
        for (int i = 0; i < nr; i++)
            for (int k = 0; k < ni; k++)
                if (!wr_a[i*8+k] || (rewrite && $urandom_range(1)))
                    send_load(0, i[2:0], k[2:0], rand_value(), 0, n);
        if (mode_reg == MODE_MUL)
        begin
            for (int k = 0; k < ni; k++)
                for (int j = 0; j < nc; j++)
                    if (!wr_b[k*8+j] || (rewrite && $urandom_range(1)))
                        send_load(1, k[2:0], j[2:0], rand_value(), 0, n);
        end
        else if (mode_reg == MODE_ADD)
        begin
            for (int i = 0; i < nr; i++)
                for (int j = 0; j < ni; j++)
                    if (!wr_b[i*8+j] || (rewrite && $urandom_range(1)))
                        send_load(1, i[2:0], j[2:0], rand_value(), 0, n);
        end
    endtask

    step_t steps [$];

    function automatic void add_step(step_t s);
        steps.insert(steps.size(), s);
    endfunction

    initial
    begin
        int n;
        bit sel;
        logic [2:0] r, c;
        elem_t e;

        rst_n = 1'b0;
        start = 1'b0;
        req_type = 1'b0;
        elem_row = '0;
        elem_col = '0;
        elem_value = '0;
        load_last = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mode_reg = MODE_MUL;
        rows_reg = 4'd8;
        cols_reg = 4'd8;
        bcols_reg = 4'd8;
        scale_reg = 32'h0001_0000;
        for (int i = 0; i < 64; i++)
        begin
            mat_a[i] = '0;
            mat_b[i] = '0;
            wr_a[i] = 0;
            wr_b[i] = 0;
        end

        //            cfg idx         data          b  r  c  value         last typed exp
        add_step('{1, REG_A_ROWS,  32'd1, 0, 0, 0, 0, 0, 0, 0, 0});
        add_step('{1, REG_A_COLS,  32'd1, 0, 0, 0, 0, 0, 0, 0, 0});
        add_step('{1, REG_B_COLS,  32'd1, 0, 0, 0, 0, 0, 0, 0, 0});
        add_step('{1, REG_OP_MODE, MODE_MUL, 0, 0, 0, 0, 0, 0, 0, 0});
        add_step('{0, 0, 0, 0, 0, 0, 32'h0001_0000, 0, 0, 0, 0});
        add_step('{0, 0, 0, 1, 0, 0, 32'h0002_0000, 1, 1, 32'h0002_0000, 0});
        add_step('{0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 0});
        add_step('{0, 0, 0, 1, 0, 0, 32'h7FFF_FFFF, 1, 1, 32'h7FFF_FFFF, 1});
        add_step('{0, 0, 0, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 0});
        add_step('{0, 0, 0, 1, 0, 0, 32'h7FFF_FFFF, 1, 1, 32'h8000_0000, 1});
        add_step('{1, REG_OP_MODE, MODE_ADD, 0, 0, 0, 0, 0, 0, 0, 0});
        add_step('{0, 0, 0, 1, 0, 0, 32'hFFFF_FFFF, 1, 1, 32'h8000_0000, 1});
        add_step('{0, 0, 0, 1, 0, 0, 32'h0000_0001, 1, 1, 32'h8000_0001, 0});
        add_step('{1, REG_OP_MODE, MODE_SCALE, 0, 0, 0, 0, 0, 0, 0, 0});
        add_step('{1, REG_SCALE, 32'hFFFF_0000, 0, 0, 0, 0, 0, 0, 0, 0});
        add_step('{0, 0, 0, 0, 0, 0, 32'h8000_0000, 1, 1, 32'h7FFF_FFFF, 1});
        add_step('{0, 0, 0, 0, 0, 0, 32'h0003_0000, 1, 1, 32'hFFFD_0000, 0});
        add_step('{1, REG_OP_MODE, MODE_NONE, 0, 0, 0, 0, 0, 0, 0, 0});
        add_step('{0, 0, 0, 0, 7, 7, 32'hFFFF_FFFF, 1, 0, 0, 0});
        add_step('{0, 0, 0, 1, 7, 7, 32'h0000_0000, 1, 0, 0, 0});
        add_step('{1, REG_A_ROWS,  32'd0, 0, 0, 0, 0, 0, 0, 0, 0});
        add_step('{1, REG_OP_MODE, MODE_SCALE, 0, 0, 0, 0, 0, 0, 0, 0});
        add_step('{0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 1, 0, 0, 0});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (steps[s])
        begin
            if (steps[s].is_cfg)
            begin
                drain();
                write_cfg(steps[s].idx, steps[s].data);
            end
            else
            begin
                send_load(steps[s].sel_b, steps[s].row, steps[s].col, steps[s].value,
                          steps[s].last, n);
                if (steps[s].typed)
                begin
                    repeat (n) void'(elem_expect_q.pop_back());
                    e.row = 0;
                    e.col = 0;
                    e.value = steps[s].exp_value;
                    e.sat = steps[s].exp_sat;
                    e.last = 1;
                    queue_expect(e);
                end
            end
        end

        while (items_sent < ITEM_TARGET)
        begin
            drain();
            case ($urandom_range(9))
                0: write_cfg(REG_OP_MODE, MODE_NONE);
                1, 2, 3: write_cfg(REG_OP_MODE, MODE_MUL);
                4, 5, 6: write_cfg(REG_OP_MODE, MODE_ADD);
                default: write_cfg(REG_OP_MODE, MODE_SCALE);
            endcase
            write_cfg(REG_A_ROWS, {28'($urandom), rand_dim()});
            write_cfg(REG_A_COLS, {28'($urandom), rand_dim()});
            write_cfg(REG_B_COLS, {28'($urandom), rand_dim()});
            write_cfg(REG_SCALE, rand_value());
            no_idle = (items_sent > 200 && items_sent < 290);
            repeat ($urandom_range(1, 3))
            begin
                if (items_sent < ITEM_TARGET)
                begin
                    cover_operands($urandom_range(3) != 0);
                    repeat ($urandom_range(2))
                        send_load(1'($urandom_range(1)), 3'($urandom), 3'($urandom),
                                  rand_value(), 0, n);
                    sel = 1'($urandom_range(1));
                    r = 3'($urandom_range(dim_of(rows_reg) - 1));
                    c = 3'($urandom_range(dim_of(cols_reg) - 1));
                    if ($urandom_range(4) == 0)
                    begin
                        r = 3'($urandom);
                        c = 3'($urandom);
                    end
                    send_load(sel, r, c, rand_value(), 1, n);
                end
            end
        end
        no_idle = 0;
        drain();

        if (errors == 0 && elem_expect_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
